### hdl/mec_pkg.sv
package mec_pkg;

   // Image and number-format limits
   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int FRACTION_BITS = 27;

   // Escape threshold: 4.0 squared-magnitude in the product format
   localparam int          ESC_SHIFT  = 2 * FRACTION_BITS + 2;
   localparam bit          CAN_ESCAPE = (ESC_SHIFT < 64);
   localparam logic [63:0] ESC_THRESH = CAN_ESCAPE ? (64'd1 << ESC_SHIFT) : 64'd0;

   // Front-to-back job queue depth
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

   // Register indexes
   localparam logic [2:0] REG_ORIGIN_REAL     = 3'd0;
   localparam logic [2:0] REG_ORIGIN_IMAG     = 3'd1;
   localparam logic [2:0] REG_STEP_REAL       = 3'd2;
   localparam logic [2:0] REG_STEP_IMAG       = 3'd3;
   localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd4;
   localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd5;
   localparam logic [2:0] REG_ITERATION_LIMIT = 3'd6;

   typedef struct packed {
      logic [9:0] pixel_column;
      logic [9:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [15:0] escape_count;
      logic [19:0] pixel_index;
      logic        outside_image;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] origin_real;
      logic signed [31:0] origin_imag;
      logic signed [31:0] step_real;
      logic signed [31:0] step_imag;
      logic [10:0]        image_width;
      logic [10:0]        image_height;
      logic [15:0]        iteration_limit;
   } cfg_type;

   // Classified pixel handed from the front to the iteration engine
   typedef struct packed {
      logic               outside;
      logic signed [31:0] c_real;
      logic signed [31:0] c_imag;
      logic [19:0]        index;
   } job_type;

   // Clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### hdl/mec_csr.sv
module mec_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output mec_pkg::cfg_type cfg
);
   import mec_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_sel;
   logic       wr_en;

   assign reg_sel    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_ORIGIN_REAL:     cfg_in.origin_real     = csr_pwdata;
            REG_ORIGIN_IMAG:     cfg_in.origin_imag     = csr_pwdata;
            REG_STEP_REAL:       cfg_in.step_real       = csr_pwdata;
            REG_STEP_IMAG:       cfg_in.step_imag       = csr_pwdata;
            REG_IMAGE_WIDTH:     cfg_in.image_width     = csr_pwdata[10:0];
            REG_IMAGE_HEIGHT:    cfg_in.image_height    = csr_pwdata[10:0];
            REG_ITERATION_LIMIT: cfg_in.iteration_limit = csr_pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_real     <= '0;
         cfg_ff.origin_imag     <= '0;
         cfg_ff.step_real       <= '0;
         cfg_ff.step_imag       <= '0;
         cfg_ff.image_width     <= 11'd1024;
         cfg_ff.image_height    <= 11'd1024;
         cfg_ff.iteration_limit <= 16'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the selected register
   always_comb begin
      case (reg_sel)
         REG_ORIGIN_REAL:     csr_prdata = cfg_ff.origin_real;
         REG_ORIGIN_IMAG:     csr_prdata = cfg_ff.origin_imag;
         REG_STEP_REAL:       csr_prdata = cfg_ff.step_real;
         REG_STEP_IMAG:       csr_prdata = cfg_ff.step_imag;
         REG_IMAGE_WIDTH:     csr_prdata = {21'd0, cfg_ff.image_width};
         REG_IMAGE_HEIGHT:    csr_prdata = {21'd0, cfg_ff.image_height};
         REG_ITERATION_LIMIT: csr_prdata = {16'd0, cfg_ff.iteration_limit};
         default:             csr_prdata = 32'd0;
      endcase
   end

endmodule

### hdl/mec_front.sv
module mec_front (
   input  logic             clock,
   input  logic             reset,
   input  mec_pkg::cfg_type cfg,
   input  logic             req_push,
   output logic             req_full,
   input  mec_pkg::req_type req_data,
   output logic             job_push,
   input  logic             job_full,
   output mec_pkg::job_type job_data
);
   import mec_pkg::*;

   logic               valid_ff, valid_in;
   logic               outside_ff;
   logic signed [42:0] prod_re_ff, prod_im_ff;
   logic [19:0]        index_ff;
   logic [10:0]        eff_w, eff_h;
   logic               accept;
   logic [21:0]        index_full;

   // Clamp the configured size to the supported maximum
   assign eff_w = (int'(cfg.image_width) > MAX_WIDTH) ? 11'(MAX_WIDTH) : cfg.image_width;
   assign eff_h = (int'(cfg.image_height) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : cfg.image_height;

   assign index_full = 22'({1'b0, req_data.pixel_row} * eff_w) + 22'(req_data.pixel_column);

   // Hold the stage while the job queue is full
   assign job_push = valid_ff && !job_full;
   assign req_full = valid_ff && job_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (job_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Classify the pixel and form the step products
   always_ff @(posedge clock) begin
      if (accept) begin
         outside_ff <= ({1'b0, req_data.pixel_column} >= eff_w)
                    || ({1'b0, req_data.pixel_row} >= eff_h);
         prod_re_ff <= $signed({1'b0, req_data.pixel_column}) * cfg.step_real;
         prod_im_ff <= $signed({1'b0, req_data.pixel_row}) * cfg.step_imag;
         index_ff   <= index_full[19:0];
      end
   end

   // Add the origin and saturate into the queued job
   always_comb begin
      job_data.outside = outside_ff;
      job_data.c_real  = sat32(64'(cfg.origin_real) + 64'(prod_re_ff));
      job_data.c_imag  = sat32(64'(cfg.origin_imag) + 64'(prod_im_ff));
      job_data.index   = index_ff;
   end

endmodule

### hdl/mec_queue.sv
module mec_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  mec_pkg::job_type push_data,
   input  logic             pop,
   output logic             empty,
   output mec_pkg::job_type head
);
   import mec_pkg::*;

   job_type                entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_PTR_W:0]     count_ff, count_in;
   logic                   do_wr, do_rd;

   assign full  = (count_ff == (JOB_PTR_W + 1)'(JOB_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];
   assign do_wr = push && !full;
   assign do_rd = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/mec_core.sv
module mec_core (
   input  logic             clock,
   input  logic             reset,
   input  mec_pkg::cfg_type cfg,
   input  logic             job_empty,
   input  mec_pkg::job_type job_head,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mec_pkg::rsp_type rsp_data
);
   import mec_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic signed [31:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [31:0] cr_ff, cr_in, ci_ff, ci_in;
   logic [19:0]        idx_ff, idx_in;
   logic signed [63:0] rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [63:0]        mag;
   logic signed [63:0] re_next, im_next;

   logic               res_wr;
   rsp_type            res_data;

   rsp_type            out_ff [2];
   logic               out_wr_ptr_ff, out_rd_ptr_ff;
   logic [1:0]         out_count_ff, out_count_in;
   logic               out_full, out_rd;

   assign mag     = 64'(rr_ff) + 64'(ii_ff);
   assign re_next = 64'(cr_ff) + ((rr_ff - ii_ff) >>> FRACTION_BITS);
   assign im_next = 64'(ci_ff) + (ri_ff >>> (FRACTION_BITS - 1));

   // Sequence one pixel: multiply state, then test-and-update state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      idx_in   = idx_ff;
      rr_in    = rr_ff;
      ii_in    = ii_ff;
      ri_in    = ri_ff;
      job_pop  = 1'b0;
      res_wr   = 1'b0;
      res_data.escape_count  = cnt_ff;
      res_data.pixel_index   = idx_ff;
      res_data.outside_image = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Start only with a result slot free, so the finish never stalls
            if (!job_empty && !out_full) begin
               job_pop = 1'b1;
               if (job_head.outside) begin
                  res_wr = 1'b1;
                  res_data.escape_count  = '0;
                  res_data.pixel_index   = '0;
                  res_data.outside_image = 1'b1;
               end else begin
                  zr_in    = job_head.c_real;
                  zi_in    = job_head.c_imag;
                  cr_in    = job_head.c_real;
                  ci_in    = job_head.c_imag;
                  idx_in   = job_head.index;
                  cnt_in   = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (cnt_ff == cfg.iteration_limit) begin
               res_wr   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rr_in    = zr_ff * zr_ff;
               ii_in    = zi_ff * zi_ff;
               ri_in    = zr_ff * zi_ff;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (CAN_ESCAPE && (mag > ESC_THRESH)) begin
               res_wr   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               zr_in    = sat32(re_next);
               zi_in    = sat32(im_next);
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      zr_ff  <= zr_in;
      zi_ff  <= zi_in;
      cr_ff  <= cr_in;
      ci_ff  <= ci_in;
      idx_ff <= idx_in;
      rr_ff  <= rr_in;
      ii_ff  <= ii_in;
      ri_ff  <= ri_in;
   end

   // Two-entry result buffer toward the consumer
   assign out_full  = (out_count_ff == 2'd2);
   assign rsp_empty = (out_count_ff == 2'd0);
   assign out_rd    = rsp_pop && !rsp_empty;
   assign rsp_data  = out_ff[out_rd_ptr_ff];

   always_comb begin
      out_count_in = out_count_ff;
      if (res_wr && !out_rd) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (out_rd && !res_wr) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff  <= '0;
         out_wr_ptr_ff <= 1'b0;
         out_rd_ptr_ff <= 1'b0;
      end else begin
         out_count_ff <= out_count_in;
         if (res_wr) begin
            out_wr_ptr_ff <= !out_wr_ptr_ff;
         end
         if (out_rd) begin
            out_rd_ptr_ff <= !out_rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_wr) begin
         out_ff[out_wr_ptr_ff] <= res_data;
      end
   end

   // A finished pixel always finds room in the result buffer
   assert property (@(posedge clock) disable iff (reset) res_wr |-> !out_full)
      else $error("result written into a full buffer");

   // The step count never runs past the limit while a pixel is active
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff <= cfg.iteration_limit))
      else $error("step count beyond iteration limit");

   // An inside pixel taken from the queue starts iterating next cycle
   assert property (@(posedge clock) disable iff (reset)
      (job_pop && !job_head.outside) |=> (state_ff == ST_MUL) && (cnt_ff == 16'd0))
      else $error("accepted pixel did not start iterating");

   // Pixels are only taken from the queue while idle
   assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (state_ff == ST_IDLE) && !job_empty)
      else $error("queue popped while busy or empty");

endmodule

### hdl/mandelbrot_escape_count_top.sv
// Mandelbrot escape-time evaluator. Push a pixel (column, row) on the request
// queue; the front stage classifies it against the configured image size and
// forms c = origin + position * step in signed Q5.27, then parks it in a
// four-entry job queue. The iteration engine takes one pixel at a time and
// runs z = z*z + c on a single shared set of three 32x32 multipliers: each
// iteration is a multiply state followed by a state that tests |z|^2 > 4 and
// updates z. A pixel that escapes finishes in the test state, one that reaches
// iteration_limit finishes in the multiply state, and a pixel outside the
// image is answered in the same cycle that takes it from the queue. A two-entry
// result buffer lets the next pixel start while a result waits to be popped.
// Results come back in request order with the step count and the linear
// index row * width + column; outside pixels report count 0, index 0 and the
// outside flag. Write configuration only while idle.
module mandelbrot_escape_count_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  mec_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mec_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import mec_pkg::*;

   cfg_type cfg;
   logic    job_push, job_full, job_pop, job_empty;
   job_type job_in, job_head;

   mec_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mec_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .job_push (job_push),
      .job_full (job_full),
      .job_data (job_in)
   );

   mec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .full      (job_full),
      .push_data (job_in),
      .pop       (job_pop),
      .empty     (job_empty),
      .head      (job_head)
   );

   mec_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_empty (job_empty),
      .job_head  (job_head),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mec_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 5_000_000;
   localparam int          RANDOM_PHASES   = 10;
   localparam int          ITEMS_PER_PHASE = 125;
   localparam int          DRAIN_CYCLES    = 50;
   localparam int          REPORT_LIMIT    = 10;

   // One directed step: either a register write or a pixel transaction
   typedef struct packed {
      logic       is_write;
      logic [2:0] reg_index;
      logic [31:0] reg_value;
      req_type    pixel;
      logic       answer_known;
      rsp_type    result;
   } plan_step_type;

   localparam req_type NO_PIXEL  = '0;
   localparam rsp_type NO_RESULT = '0;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   req_type     req_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cfg_type     view_cfg;
   rsp_type     awaited_results[$];
   rsp_type     oldest_due;
   int          mismatch_count = 0;
   int          send_idle_pct = 15;
   int          recv_stall_pct = 73;
   int unsigned cycle_count = 0;

   // Directed steps: reset values, size and limit extremes, saturation of c,
   // the bounded tip at -2, and a point that never escapes at the top limit
   plan_step_type directed_plan [0:39] = '{
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd0, 10'd0}, 1'b1, '{16'd256, 20'd0, 1'b0}},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd1023, 10'd1023}, 1'b1,
        '{16'd256, 20'hFFFFF, 1'b0}},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd1, 10'd2}, 1'b1, '{16'd256, 20'd2049, 1'b0}},
      '{1'b1, REG_ITERATION_LIMIT, 32'd0, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd5, 10'd3}, 1'b1, '{16'd0, 20'd3077, 1'b0}},
      '{1'b1, REG_IMAGE_WIDTH, 32'd1, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b1, REG_IMAGE_HEIGHT, 32'd1, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd0, 10'd0}, 1'b1, '{16'd0, 20'd0, 1'b0}},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd1, 10'd0}, 1'b1, '{16'd0, 20'd0, 1'b1}},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd0, 10'd1}, 1'b1, '{16'd0, 20'd0, 1'b1}},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd1023, 10'd1023}, 1'b1, '{16'd0, 20'd0, 1'b1}},
      '{1'b1, REG_IMAGE_WIDTH, 32'd0, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd0, 10'd0}, 1'b1, '{16'd0, 20'd0, 1'b1}},
      '{1'b1, REG_IMAGE_WIDTH, 32'd2047, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b1, REG_IMAGE_HEIGHT, 32'd2047, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd1023, 10'd1023}, 1'b1,
        '{16'd0, 20'hFFFFF, 1'b0}},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd1023, 10'd0}, 1'b1, '{16'd0, 20'd1023, 1'b0}},
      '{1'b1, REG_ITERATION_LIMIT, 32'h0000_FFFF, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b1, REG_ORIGIN_REAL, 32'h7FFF_FFFF, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd0, 10'd0}, 1'b1, '{16'd0, 20'd0, 1'b0}},
      '{1'b1, REG_ORIGIN_REAL, 32'h8000_0000, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b1, REG_STEP_REAL, 32'h7FFF_FFFF, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd0, 10'd0}, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd1023, 10'd5}, 1'b0, NO_RESULT},
      '{1'b1, REG_ORIGIN_REAL, 32'h0200_0000, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b1, REG_STEP_REAL, 32'h0, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd0, 10'd0}, 1'b0, NO_RESULT},
      '{1'b1, REG_ITERATION_LIMIT, 32'd1000, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b1, REG_ORIGIN_REAL, 32'hF000_0000, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd0, 10'd0}, 1'b0, NO_RESULT},
      '{1'b1, REG_ORIGIN_IMAG, 32'h8000_0000, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b1, REG_STEP_IMAG, 32'h0080_0000, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd0, 10'd1023}, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd0, 10'd0}, 1'b0, NO_RESULT},
      '{1'b1, REG_ORIGIN_IMAG, 32'h0800_0000, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b1, REG_STEP_IMAG, 32'hFF00_0000, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b1, REG_STEP_REAL, 32'h0040_0000, NO_PIXEL, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd48, 10'd8}, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd40, 10'd4}, 1'b0, NO_RESULT},
      '{1'b0, REG_ORIGIN_REAL, 32'h0, '{10'd1023, 10'd1023}, 1'b0, NO_RESULT}
   };

   mandelbrot_escape_count_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Clamp a wide sum to the signed 32-bit range
   function automatic logic signed [31:0] clamp_q32(input longint v);
      logic signed [31:0] r;
      if (v > longint'(32'sh7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -longint'(64'sh8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Iterate z = z*z + c from z = c; count steps taken before |z|^2 > 4
   function automatic logic [15:0] escape_steps(input logic signed [31:0] cr,
                                                input logic signed [31:0] ci,
                                                input logic [15:0] step_cap);
      logic signed [31:0] zr;
      logic signed [31:0] zi;
      longint             rr;
      longint             ii;
      longint             ri;
      logic [63:0]        mag;
      int unsigned        n;
      zr = cr;
      zi = ci;
      for (n = 0; n < step_cap; n++) begin
         rr  = longint'(zr) * longint'(zr);
         ii  = longint'(zi) * longint'(zi);
         ri  = longint'(zr) * longint'(zi);
         mag = rr + ii;
         if (CAN_ESCAPE && mag > ESC_THRESH) break;
         zr = clamp_q32(longint'(cr) + ((rr - ii) >>> FRACTION_BITS));
         zi = clamp_q32(longint'(ci) + (ri >>> (FRACTION_BITS - 1)));
      end
      return n[15:0];
   endfunction

   // Expected result of one pixel under the current register view
   function automatic rsp_type predict_pixel(input req_type pix);
      rsp_type            r;
      int unsigned        ew;
      int unsigned        eh;
      int unsigned        col;
      int unsigned        row;
      logic signed [31:0] o_re;
      logic signed [31:0] o_im;
      logic signed [31:0] s_re;
      logic signed [31:0] s_im;
      logic signed [31:0] cr;
      logic signed [31:0] ci;
      ew   = (view_cfg.image_width > MAX_WIDTH) ? MAX_WIDTH : view_cfg.image_width;
      eh   = (view_cfg.image_height > MAX_HEIGHT) ? MAX_HEIGHT : view_cfg.image_height;
      col  = pix.pixel_column;
      row  = pix.pixel_row;
      o_re = view_cfg.origin_real;
      o_im = view_cfg.origin_imag;
      s_re = view_cfg.step_real;
      s_im = view_cfg.step_imag;
      r    = '0;
      if (col >= ew || row >= eh) begin
         r.outside_image = 1'b1;
      end else begin
         cr = clamp_q32(longint'(o_re) + longint'(col) * longint'(s_re));
         ci = clamp_q32(longint'(o_im) + longint'(row) * longint'(s_im));
         r.escape_count = escape_steps(cr, ci, view_cfg.iteration_limit);
         r.pixel_index  = 20'(row * ew + col);
      end
      return r;
   endfunction

   // Write one register through the setup and access phases
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_ORIGIN_REAL:     view_cfg.origin_real     = value;
         REG_ORIGIN_IMAG:     view_cfg.origin_imag     = value;
         REG_STEP_REAL:       view_cfg.step_real       = value;
         REG_STEP_IMAG:       view_cfg.step_imag       = value;
         REG_IMAGE_WIDTH:     view_cfg.image_width     = value[10:0];
         REG_IMAGE_HEIGHT:    view_cfg.image_height    = value[10:0];
         REG_ITERATION_LIMIT: view_cfg.iteration_limit = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offer one pixel transaction and queue its expected result on acceptance
   task automatic push_pixel(input req_type pix, input logic answer_known,
                             input rsp_type answer);
      rsp_type due;
      due = answer_known ? answer : predict_pixel(pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= pix;
      do @(posedge clock); while (req_full);
      awaited_results.push_back(due);
   endtask

   // Hold off new pixels until every queued result has been popped
   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [10:0] pick_size();
      logic [10:0] s;
      case ($urandom_range(7))
         0:       s = 11'd1;
         1:       s = 11'd1024;
         2:       s = 11'd2047;
         default: s = 11'($urandom_range(2, 1023));
      endcase
      return s;
   endfunction

   // Program a fresh view: mostly a window over the set, sometimes raw noise
   task automatic program_view();
      logic [10:0]        w;
      logic [10:0]        h;
      int                 ew;
      int                 eh;
      logic signed [31:0] o_re;
      logic signed [31:0] o_im;
      logic signed [31:0] s_re;
      logic signed [31:0] s_im;
      logic [15:0]        step_cap;
      if ($urandom_range(9) < 7) begin
         w    = pick_size();
         h    = pick_size();
         ew   = (w > MAX_WIDTH) ? MAX_WIDTH : w;
         eh   = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
         // span about 3.0 in each direction, starting near -2.25 and -1.5
         s_re = 402653184 / ew;
         s_im = 402653184 / eh;
         o_re = -301989888 + int'($urandom_range(0, 1 << 26));
         o_im = -201326592 + int'($urandom_range(0, 1 << 25));
         if ($urandom_range(3) == 0) begin
            o_re = 100663296 - int'($urandom_range(0, 1 << 25));
            s_re = -s_re;
         end
         if ($urandom_range(3) == 0) begin
            o_im = 201326592 - int'($urandom_range(0, 1 << 25));
            s_im = -s_im;
         end
         case ($urandom_range(9))
            0:       step_cap = 16'd0;
            1, 2, 3: step_cap = 16'($urandom_range(49, 300));
            default: step_cap = 16'($urandom_range(1, 48));
         endcase
      end else begin
         w        = 11'($urandom_range(0, 2047));
         h        = 11'($urandom_range(0, 2047));
         o_re     = $urandom;
         o_im     = $urandom;
         s_re     = $urandom;
         s_im     = $urandom;
         step_cap = 16'($urandom_range(0, 64));
      end
      csr_write(REG_ORIGIN_REAL, o_re);
      csr_write(REG_ORIGIN_IMAG, o_im);
      csr_write(REG_STEP_REAL, s_re);
      csr_write(REG_STEP_IMAG, s_im);
      csr_write(REG_IMAGE_WIDTH, {21'd0, w});
      csr_write(REG_IMAGE_HEIGHT, {21'd0, h});
      csr_write(REG_ITERATION_LIMIT, {16'd0, step_cap});
   endtask

   // Pick a pixel, mostly inside the configured image
   function automatic req_type pick_pixel();
      req_type     p;
      int unsigned ew;
      int unsigned eh;
      ew = (view_cfg.image_width > MAX_WIDTH) ? MAX_WIDTH : view_cfg.image_width;
      eh = (view_cfg.image_height > MAX_HEIGHT) ? MAX_HEIGHT : view_cfg.image_height;
      if ($urandom_range(99) < 85 && ew != 0 && eh != 0) begin
         p.pixel_column = 10'($urandom_range(0, ew - 1));
         p.pixel_row    = 10'($urandom_range(0, eh - 1));
      end else begin
         p.pixel_column = 10'($urandom_range(0, 1023));
         p.pixel_row    = 10'($urandom_range(0, 1023));
      end
      return p;
   endfunction

   // Pop results at random and check each against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_pop && !rsp_empty) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected result transaction: count %0d index %0d outside %0b",
                           rsp_data.escape_count, rsp_data.pixel_index,
                           rsp_data.outside_image);
               end
            end else begin
               oldest_due = awaited_results.pop_front();
               if (rsp_data.escape_count !== oldest_due.escape_count ||
                   rsp_data.pixel_index !== oldest_due.pixel_index ||
                   rsp_data.outside_image !== oldest_due.outside_image) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("result mismatch: expected count %0d index %0d outside %0b,",
                              oldest_due.escape_count, oldest_due.pixel_index,
                              oldest_due.outside_image);
                     $display("   got count %0d index %0d outside %0b at cycle %0d",
                              rsp_data.escape_count, rsp_data.pixel_index,
                              rsp_data.outside_image, cycle_count);
                  end
               end
            end
         end
      end
   end

   // Stop a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      view_cfg                 = '0;
      view_cfg.image_width     = 11'd1024;
      view_cfg.image_height    = 11'd1024;
      view_cfg.iteration_limit = 16'd256;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_plan[k]) begin
         if (directed_plan[k].is_write) begin
            drain_results();
            csr_write(directed_plan[k].reg_index, directed_plan[k].reg_value);
         end else begin
            push_pixel(directed_plan[k].pixel, directed_plan[k].answer_known,
                       directed_plan[k].result);
         end
      end

      // Random phases: slow receiver, then slow sender, then full speed
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 4) begin
            send_idle_pct  = 15;
            recv_stall_pct = 73;
         end else if (phase < 7) begin
            send_idle_pct  = 73;
            recv_stall_pct = 15;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         drain_results();
         program_view();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            push_pixel(pick_pixel(), 1'b0, NO_RESULT);
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### sim.f
hdl/mec_pkg.sv
hdl/mec_csr.sv
hdl/mec_front.sv
hdl/mec_queue.sv
hdl/mec_core.sv
hdl/mandelbrot_escape_count_top.sv
tb/tb_top.sv
